/* rtl/sccb_pkg.sv */
// ----------------------------------------------------------------------------
// sccb_pkg
// shared types and constants for the sccb bit-level master: command codes,
// the sequencer state record and the reset value of the bus delay
// ----------------------------------------------------------------------------
package sccb_pkg;

    localparam int unsigned ACT_W    = 3;
    localparam int unsigned PHASE_W  = 4;
    localparam int unsigned BIT_W    = 4;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned BYTE_W   = 8;

    // command codes carried by the action field
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NOACK = 3'd5;

    // sequence phases
    localparam logic [PHASE_W-1:0] PH_0 = 4'd0;
    localparam logic [PHASE_W-1:0] PH_1 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_2 = 4'd2;
    localparam logic [PHASE_W-1:0] PH_3 = 4'd3;

    localparam logic [BIT_W-1:0]   BITS_PER_BYTE = 4'd8;
    localparam logic [DELAY_W-1:0] DELAY_RESET   = 16'd50;

    typedef struct packed {
        logic [ACT_W-1:0]   cmd;
        logic [PHASE_W-1:0] phase;
        logic [BIT_W-1:0]   bit_cnt;
        logic [DELAY_W-1:0] dly_cnt;
        logic [BYTE_W-1:0]  shift;
        logic               scl;
        logic               sda_latch;
        logic               sda_in_mode;
        logic [BYTE_W-1:0]  rd_result;
        logic               ack;
    } seq_state_t;

endpackage

/* rtl/sccb_step.sv */
// ----------------------------------------------------------------------------
// sccb_step
// next-state logic of the bit sequencer for one clock tick: command launch,
// delay countdown and the pin group that follows an expired delay
// ----------------------------------------------------------------------------
module sccb_step (
    input  sccb_pkg::seq_state_t                 cur,
    input  logic [sccb_pkg::ACT_W-1:0]           action,
    input  logic [sccb_pkg::BYTE_W-1:0]          wr_data,
    input  logic                                 sda_level,
    input  logic [sccb_pkg::DELAY_W-1:0]         delay_ticks,
    output sccb_pkg::seq_state_t                 nxt,
    output logic                                 done
);
    import sccb_pkg::*;

    logic [DELAY_W-1:0] load_val;
    logic [DELAY_W-1:0] dly_dec;
    logic [BIT_W-1:0]   bit_inc;
    logic               expired;

    assign load_val = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
    assign dly_dec  = (cur.dly_cnt != '0) ? cur.dly_cnt - DELAY_W'(1) : cur.dly_cnt;
    assign bit_inc  = cur.bit_cnt + BIT_W'(1);
    assign expired  = (dly_dec == '0);

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        if (cur.cmd == ACT_NONE) begin
            if (action >= ACT_START && action <= ACT_NOACK) begin
                nxt.cmd     = action;
                nxt.phase   = PH_0;
                nxt.bit_cnt = '0;
                nxt.dly_cnt = load_val;
                unique case (action)
                    ACT_START: begin
                        nxt.sda_latch = 1'b1;
                        nxt.scl       = 1'b1;
                    end
                    ACT_STOP:  nxt.sda_latch = 1'b0;
                    ACT_WRITE: begin
                        nxt.sda_latch = wr_data[BYTE_W-1];
                        nxt.shift     = {wr_data[BYTE_W-2:0], 1'b0};
                    end
                    ACT_READ: begin
                        nxt.shift       = '0;
                        nxt.sda_in_mode = 1'b1;
                    end
                    default: ;
                endcase
            end
        end else begin
            nxt.dly_cnt = dly_dec;
            if (expired) begin
                unique case (cur.cmd)
                    ACT_START: begin
                        if (cur.phase == PH_0) begin
                            nxt.sda_latch = 1'b0;
                            nxt.phase     = PH_1;
                            nxt.dly_cnt   = load_val;
                        end else begin
                            nxt.scl = 1'b0;
                            done    = 1'b1;
                        end
                    end
                    ACT_STOP: begin
                        if (cur.phase == PH_0) begin
                            nxt.scl     = 1'b1;
                            nxt.phase   = PH_1;
                            nxt.dly_cnt = load_val;
                        end else if (cur.phase == PH_1) begin
                            nxt.sda_latch = 1'b1;
                            nxt.phase     = PH_2;
                            nxt.dly_cnt   = load_val;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    ACT_NOACK: begin
                        if (cur.phase == PH_0) begin
                            nxt.sda_latch = 1'b1;
                            nxt.scl       = 1'b1;
                            nxt.phase     = PH_1;
                            nxt.dly_cnt   = load_val;
                        end else if (cur.phase == PH_1) begin
                            nxt.scl     = 1'b0;
                            nxt.phase   = PH_2;
                            nxt.dly_cnt = load_val;
                        end else if (cur.phase == PH_2) begin
                            nxt.sda_latch = 1'b0;
                            nxt.phase     = PH_3;
                            nxt.dly_cnt   = load_val;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    ACT_WRITE: begin
                        if (cur.phase == PH_0) begin
                            nxt.scl     = 1'b1;
                            nxt.phase   = PH_1;
                            nxt.dly_cnt = load_val;
                        end else if (cur.phase == PH_1) begin
                            nxt.scl     = 1'b0;
                            nxt.bit_cnt = bit_inc;
                            nxt.dly_cnt = load_val;
                            if (bit_inc < BITS_PER_BYTE) begin
                                nxt.sda_latch = cur.shift[BYTE_W-1];
                                nxt.shift     = {cur.shift[BYTE_W-2:0], 1'b0};
                                nxt.phase     = PH_0;
                            end else begin
                                nxt.sda_in_mode = 1'b1;
                                nxt.phase       = PH_2;
                            end
                        end else if (cur.phase == PH_2) begin
                            nxt.scl     = 1'b1;
                            nxt.phase   = PH_3;
                            nxt.dly_cnt = load_val;
                        end else begin
                            // acknowledge: low level means the slave took the byte
                            nxt.ack         = ~sda_level;
                            nxt.scl         = 1'b0;
                            nxt.sda_in_mode = 1'b0;
                            done            = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (cur.phase == PH_0) begin
                            nxt.scl     = 1'b1;
                            nxt.shift   = {cur.shift[BYTE_W-2:0], sda_level};
                            nxt.phase   = PH_1;
                            nxt.dly_cnt = load_val;
                        end else begin
                            nxt.scl     = 1'b0;
                            nxt.bit_cnt = bit_inc;
                            if (bit_inc < BITS_PER_BYTE) begin
                                nxt.phase   = PH_0;
                                nxt.dly_cnt = load_val;
                            end else begin
                                nxt.sda_in_mode = 1'b0;
                                nxt.rd_result   = cur.shift;
                                done            = 1'b1;
                            end
                        end
                    end
                    default: done = 1'b1;
                endcase
                if (done) begin
                    nxt.cmd   = ACT_NONE;
                    nxt.phase = PH_0;
                end
            end
        end
    end

endmodule

/* rtl/sccb_bit_level_master_unit.sv */
// ----------------------------------------------------------------------------
// sccb_bit_level_master_unit
// sccb / i2c bit-bang master: one input transaction is one bus tick
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the bus sequencer and may carry a
// command (start, stop, write byte, read byte, send no-acknowledge), the byte
// to write and the sampled sda level. Every input transaction yields exactly
// one result transaction with the scl and sda drive levels, busy/done status,
// the last read byte and the last write's acknowledge. A command is launched
// only while idle; commands that arrive while busy are dropped. Every bus
// delay lasts delay_ticks ticks (zero counts as one); a new value written on
// the configuration port applies from the next delay that gets loaded.
// Throughput is one transaction per clock: the sequencer state and the result
// register both update in the accepting cycle, so the only limit is the
// result register, which lets a new transaction in whenever it is empty or
// being taken in the same cycle. A result shows in the cycle after its input is accepted.
// ----------------------------------------------------------------------------
module sccb_bit_level_master_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [sccb_pkg::DELAY_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sccb_pkg::ACT_W-1:0]          s_action,
    input  logic [sccb_pkg::BYTE_W-1:0]         s_wr_data,
    input  logic                                s_sda_level,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_scl,
    output logic                                m_sda_release,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [sccb_pkg::BYTE_W-1:0]         m_rd_data,
    output logic                                m_ack_ok
);
    import sccb_pkg::*;

    // configuration register
    logic [DELAY_W-1:0] delay_ticks_reg;

    // sequencer state
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       step_done;

    // result register
    logic              m_valid_reg;
    logic              scl_reg;
    logic              sda_release_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              ack_reg;

    logic s_fire;

    // input accepted while the result slot is free or draining this cycle
    assign s_ready = ~m_valid_reg | m_ready;
    assign s_fire  = s_valid & s_ready;

    // one tick of the sequencer
    sccb_step u_step (
        .cur         (state_reg),
        .action      (s_action),
        .wr_data     (s_wr_data),
        .sda_level   (s_sda_level),
        .delay_ticks (delay_ticks_reg),
        .nxt         (state_next),
        .done        (step_done)
    );

    // configuration write, no handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= DELAY_RESET;
        end else if (cfg_wr_en) begin
            delay_ticks_reg <= cfg_wr_data;
        end
    end

    // sequencer state advances once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.cmd         <= ACT_NONE;
            state_reg.phase       <= PH_0;
            state_reg.bit_cnt     <= '0;
            state_reg.dly_cnt     <= '0;
            state_reg.shift       <= '0;
            state_reg.scl         <= 1'b1;
            state_reg.sda_latch   <= 1'b1;
            state_reg.sda_in_mode <= 1'b0;
            state_reg.rd_result   <= '0;
            state_reg.ack         <= 1'b0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, taken from the post-tick state
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            scl_reg         <= state_next.scl;
            sda_release_reg <= state_next.sda_in_mode | state_next.sda_latch;
            busy_reg        <= (state_next.cmd != ACT_NONE);
            done_reg        <= step_done;
            rd_data_reg     <= state_next.rd_result;
            ack_reg         <= state_next.ack;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_scl         = scl_reg;
    assign m_sda_release = sda_release_reg;
    assign m_busy_res    = busy_reg;
    assign m_done_res    = done_reg;
    assign m_rd_data     = rd_data_reg;
    assign m_ack_ok      = ack_reg;

`ifndef ASSERT_OFF
    // a command that finishes is never reported busy on the same tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_busy_res && m_done_res))
        else $error("done and busy both set in one result");

    // while a command runs, a delay is always pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.cmd != ACT_NONE) |-> (state_reg.dly_cnt != '0))
        else $error("busy sequencer with empty delay counter");

    // sda is released as an input only within a write or read
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.sda_in_mode |-> (state_reg.cmd == ACT_WRITE || state_reg.cmd == ACT_READ))
        else $error("sda input mode outside write or read");

    // a finishing tick leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && step_done) |=> (state_reg.cmd == ACT_NONE))
        else $error("sequencer not idle after command end");
`endif

endmodule

/* tb/sccb_bit_level_master_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sccb_bit_level_master_unit_tb
// self-checking bench for the sccb bit-level master: every input transaction
// is one bus tick, and the scl/sda drive, busy/done status, read byte and
// acknowledge flag of each result transaction are compared with a cycle model
// of the sequencer kept inside the bench. A short stimulus table comes first,
// then random command streams at several bus delays, from the smallest up to
// a long one, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sccb_bit_level_master_unit_tb;
    import sccb_pkg::*;

    // action codes outside the command set, ignored by the block
    localparam logic [ACT_W-1:0]   ACT_RSVD_LO = 3'd6;
    localparam logic [ACT_W-1:0]   ACT_RSVD_HI = 3'd7;
    localparam logic [DELAY_W-1:0] DELAY_LONG  = 16'd64;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int NUM_DIR          = 15;
    localparam int MAX_SHOWN        = 10;

    // one result transaction
    typedef struct packed {
        logic              scl;
        logic              sda_rel;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rd;
        logic              ack;
    } bus_pins_t;

    // one row of the stimulus table: a delay write, or reps ticks of one item
    typedef struct packed {
        logic               cfg;
        logic [DELAY_W-1:0] dly;
        logic [ACT_W-1:0]   act;
        logic [BYTE_W-1:0]  wr;
        logic               sda;
        logic [7:0]         reps;
        logic               chk;
        bus_pins_t          want;
    } dir_row_t;

    localparam bus_pins_t PINS_IDLE  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam bus_pins_t PINS_START = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               cfg_wr_en   = 1'b0;
    logic [DELAY_W-1:0] cfg_wr_data = '0;

    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action    = ACT_NONE;
    logic [BYTE_W-1:0] s_wr_data   = '0;
    logic              s_sda_level = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_scl;
    logic              m_sda_release;
    logic              m_busy_res;
    logic              m_done_res;
    logic [BYTE_W-1:0] m_rd_data;
    logic              m_ack_ok;

    // bench-side copy of the sequencer and of the delay register
    seq_state_t         seq_st;
    logic [DELAY_W-1:0] delay_setting;

    // pin levels still owed by the block, oldest first
    bus_pins_t pins_due[$];

    int       mismatches  = 0;
    int       results_seen = 0;
    int       burst_left  = 0;
    bit       sender_gaps = 1'b1;
    bit [9:0] rx_tick     = '0;

    dir_row_t dir_tab [NUM_DIR];

    sccb_bit_level_master_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_wr_data     (s_wr_data),
        .s_sda_level   (s_sda_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl         (m_scl),
        .m_sda_release (m_sda_release),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_rd_data     (m_rd_data),
        .m_ack_ok      (m_ack_ok)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------

    // a zero delay setting counts as one tick
    function automatic void reload_delay();
        seq_st.dly_cnt = (delay_setting == '0) ? 16'd1 : delay_setting;
    endfunction

    // msb of the shift register goes onto the sda latch
    function automatic void shift_out_msb();
        seq_st.sda_latch = seq_st.shift[BYTE_W-1];
        seq_st.shift     = {seq_st.shift[BYTE_W-2:0], 1'b0};
    endfunction

    // pin group that follows an expired delay; returns 1 on the last group
    function automatic logic run_pin_group(input logic sda_in);
        logic fin;
        fin = 1'b0;
        case (seq_st.cmd)
            ACT_START: begin
                if (seq_st.phase == PH_0) begin
                    seq_st.sda_latch = 1'b0;
                    seq_st.phase     = PH_1;
                    reload_delay();
                end else begin
                    seq_st.scl = 1'b0;
                    fin        = 1'b1;
                end
            end
            ACT_STOP: begin
                if (seq_st.phase == PH_0) begin
                    seq_st.scl   = 1'b1;
                    seq_st.phase = PH_1;
                    reload_delay();
                end else if (seq_st.phase == PH_1) begin
                    seq_st.sda_latch = 1'b1;
                    seq_st.phase     = PH_2;
                    reload_delay();
                end else begin
                    fin = 1'b1;
                end
            end
            ACT_NOACK: begin
                if (seq_st.phase == PH_0) begin
                    seq_st.sda_latch = 1'b1;
                    seq_st.scl       = 1'b1;
                    seq_st.phase     = PH_1;
                    reload_delay();
                end else if (seq_st.phase == PH_1) begin
                    seq_st.scl   = 1'b0;
                    seq_st.phase = PH_2;
                    reload_delay();
                end else if (seq_st.phase == PH_2) begin
                    seq_st.sda_latch = 1'b0;
                    seq_st.phase     = PH_3;
                    reload_delay();
                end else begin
                    fin = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (seq_st.phase == PH_0) begin
                    seq_st.scl   = 1'b1;
                    seq_st.phase = PH_1;
                    reload_delay();
                end else if (seq_st.phase == PH_1) begin
                    seq_st.scl     = 1'b0;
                    seq_st.bit_cnt = seq_st.bit_cnt + 4'd1;
                    if (seq_st.bit_cnt < BITS_PER_BYTE) begin
                        shift_out_msb();
                        seq_st.phase = PH_0;
                    end else begin
                        // ninth clock: release sda for the acknowledge
                        seq_st.sda_in_mode = 1'b1;
                        seq_st.phase       = PH_2;
                    end
                    reload_delay();
                end else if (seq_st.phase == PH_2) begin
                    seq_st.scl   = 1'b1;
                    seq_st.phase = PH_3;
                    reload_delay();
                end else begin
                    seq_st.ack         = ~sda_in;
                    seq_st.scl         = 1'b0;
                    seq_st.sda_in_mode = 1'b0;
                    fin                = 1'b1;
                end
            end
            ACT_READ: begin
                if (seq_st.phase == PH_0) begin
                    seq_st.scl   = 1'b1;
                    seq_st.shift = {seq_st.shift[BYTE_W-2:0], sda_in};
                    seq_st.phase = PH_1;
                    reload_delay();
                end else begin
                    seq_st.scl     = 1'b0;
                    seq_st.bit_cnt = seq_st.bit_cnt + 4'd1;
                    if (seq_st.bit_cnt < BITS_PER_BYTE) begin
                        seq_st.phase = PH_0;
                        reload_delay();
                    end else begin
                        seq_st.sda_in_mode = 1'b0;
                        seq_st.rd_result   = seq_st.shift;
                        fin                = 1'b1;
                    end
                end
            end
            default: fin = 1'b1;
        endcase
        return fin;
    endfunction

    // one bus tick: advances the model and returns the pins it should show
    function automatic bus_pins_t next_bus_pins(input logic [ACT_W-1:0] act,
                                                input logic [BYTE_W-1:0] wr,
                                                input logic sda_in);
        bus_pins_t p;
        logic      fin;
        fin = 1'b0;
        if (seq_st.cmd == ACT_NONE) begin
            if (act >= ACT_START && act <= ACT_NOACK) begin
                seq_st.cmd     = act;
                seq_st.phase   = PH_0;
                seq_st.bit_cnt = '0;
                case (act)
                    ACT_START: begin
                        seq_st.sda_latch = 1'b1;
                        seq_st.scl       = 1'b1;
                    end
                    ACT_STOP:  seq_st.sda_latch = 1'b0;
                    ACT_WRITE: begin
                        seq_st.shift = wr;
                        shift_out_msb();
                    end
                    ACT_READ: begin
                        seq_st.shift       = '0;
                        seq_st.sda_in_mode = 1'b1;
                    end
                    default: ;
                endcase
                reload_delay();
            end
        end else begin
            if (seq_st.dly_cnt != '0)
                seq_st.dly_cnt = seq_st.dly_cnt - 16'd1;
            if (seq_st.dly_cnt == '0)
                fin = run_pin_group(sda_in);
            if (fin) begin
                seq_st.cmd   = ACT_NONE;
                seq_st.phase = PH_0;
            end
        end
        p.scl     = seq_st.scl;
        p.sda_rel = seq_st.sda_in_mode ? 1'b1 : seq_st.sda_latch;
        p.busy    = (seq_st.cmd != ACT_NONE);
        p.done    = fin;
        p.rd      = seq_st.rd_result;
        p.ack     = seq_st.ack;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offers one tick and waits for its transaction; with use_want set the
    // typed value is what the block has to show, otherwise the model's
    task automatic push_tick(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] wr,
                             input logic sda, input bit use_want, input bus_pins_t want);
        int        gap;
        bus_pins_t got;
        // bursts of random length, idle gaps in between (sometimes none)
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0 || !sender_gaps) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_wr_data   <= wr;
        s_sda_level <= sda;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left = burst_left - 1;
        got = next_bus_pins(act, wr, sda);
        pins_due.push_back(use_want ? want : got);
    endtask

    // random noise tick, any action code
    task automatic push_noise();
        push_tick(ACT_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, PINS_IDLE);
    endtask

    // delay register write: the sender holds off until every result is back
    task automatic write_delay_reg(input logic [DELAY_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pins_due.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        delay_setting  = value;
    endtask

    // random ticks: commands are likely while idle, anything goes while busy
    task automatic run_random(input int count);
        int               r;
        logic [ACT_W-1:0] act;
        repeat (count) begin
            if (seq_st.cmd == ACT_NONE) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    act = ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
                else if (r < 25)
                    act = ACT_NONE;
                else
                    act = ACT_W'($urandom_range(ACT_START, ACT_NOACK));
            end else begin
                act = ACT_W'($urandom_range(0, 7));
            end
            push_tick(act, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, PINS_IDLE);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        seq_st           = '0;
        seq_st.cmd       = ACT_NONE;
        seq_st.scl       = 1'b1;
        seq_st.sda_latch = 1'b1;
        delay_setting    = DELAY_RESET;

        // reset values, ignored action codes, then a start at the reset delay
        // whose delay is rewritten halfway through
        dir_tab[0]  = '{1'b0, 16'd0, ACT_NONE,    8'h00, 1'b0, 8'd1,  1'b1, PINS_IDLE};
        dir_tab[1]  = '{1'b0, 16'd0, ACT_RSVD_LO, 8'hFF, 1'b1, 8'd1,  1'b1, PINS_IDLE};
        dir_tab[2]  = '{1'b0, 16'd0, ACT_RSVD_HI, 8'h00, 1'b0, 8'd1,  1'b1, PINS_IDLE};
        dir_tab[3]  = '{1'b0, 16'd0, ACT_START,   8'h00, 1'b0, 8'd1,  1'b1, PINS_START};
        // stop commands while busy are dropped
        dir_tab[4]  = '{1'b0, 16'd0, ACT_STOP,    8'hFF, 1'b1, 8'd49, 1'b0, PINS_IDLE};
        // zero delay counts as one; the running start picks it up at its next delay
        dir_tab[5]  = '{1'b1, 16'd0, ACT_NONE,    8'h00, 1'b0, 8'd0,  1'b0, PINS_IDLE};
        dir_tab[6]  = '{1'b0, 16'd0, ACT_NONE,    8'h00, 1'b0, 8'd3,  1'b0, PINS_IDLE};
        // write all ones acknowledged, write all zeros not acknowledged
        dir_tab[7]  = '{1'b0, 16'd0, ACT_WRITE,   8'hFF, 1'b0, 8'd19, 1'b0, PINS_IDLE};
        dir_tab[8]  = '{1'b0, 16'd0, ACT_WRITE,   8'h00, 1'b1, 8'd19, 1'b0, PINS_IDLE};
        // read with sda high, then low: latch keeps the last write bit after
        dir_tab[9]  = '{1'b0, 16'd0, ACT_READ,    8'h5A, 1'b1, 8'd17, 1'b0, PINS_IDLE};
        dir_tab[10] = '{1'b0, 16'd0, ACT_READ,    8'hA5, 1'b0, 8'd17, 1'b0, PINS_IDLE};
        dir_tab[11] = '{1'b0, 16'd0, ACT_NOACK,   8'h00, 1'b0, 8'd5,  1'b0, PINS_IDLE};
        dir_tab[12] = '{1'b0, 16'd0, ACT_STOP,    8'h00, 1'b1, 8'd4,  1'b0, PINS_IDLE};
        dir_tab[13] = '{1'b0, 16'd0, ACT_START,   8'hFF, 1'b1, 8'd3,  1'b0, PINS_IDLE};
        dir_tab[14] = '{1'b0, 16'd0, ACT_NONE,    8'h00, 1'b0, 8'd1,  1'b0, PINS_IDLE};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            if (dir_tab[i].cfg) begin
                write_delay_reg(dir_tab[i].dly);
            end else begin
                for (int k = 0; k < dir_tab[i].reps; k++)
                    push_tick(dir_tab[i].act, dir_tab[i].wr, dir_tab[i].sda,
                              dir_tab[i].chk && k == 0, dir_tab[i].want);
            end
        end

        // random phases; the block may still be mid-command at each delay write
        write_delay_reg(16'd1);
        run_random(RANDOM_PER_PHASE);
        write_delay_reg(16'd0);
        run_random(RANDOM_PER_PHASE);
        write_delay_reg(16'd2);
        run_random(RANDOM_PER_PHASE);
        write_delay_reg(16'd3);
        run_random(RANDOM_PER_PHASE);

        // long delay: let the bus go idle first so only one start runs at it,
        // then feed noise back to back until it has finished
        while (seq_st.cmd != ACT_NONE)
            push_noise();
        write_delay_reg(DELAY_LONG);
        sender_gaps = 1'b0;
        push_tick(ACT_START, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b0, PINS_IDLE);
        while (seq_st.cmd != ACT_NONE)
            push_noise();
        sender_gaps = 1'b1;

        write_delay_reg(16'd1);
        run_random(RANDOM_PER_PHASE);
        write_delay_reg(16'd4);
        run_random(RANDOM_PER_PHASE);

        // drain, then keep the clock running to catch any stray result
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pins_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("[sccb_bit_level_master_unit] OK");
        else
            $display("[sccb_bit_level_master_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stretches of always ready, 3-in-4 random,
    // a fixed one-in-four stall and coin-flip ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 10'd1;
            case (rx_tick[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= (rx_tick[1:0] != 2'b11);
                default: m_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result checker: values read here are the ones present before the edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        bus_pins_t want;
        bus_pins_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_scl, m_sda_release, m_busy_res, m_done_res, m_rd_data, m_ack_ok};
            if (pins_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_SHOWN)
                    $display("result transaction %0d with nothing outstanding", results_seen);
            end else begin
                want = pins_due.pop_front();
                if (seen !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch on result %0d: exp scl=%b sda=%b busy=%b done=%b ",
                                  "rd=%h ack=%b, got scl=%b sda=%b busy=%b done=%b rd=%h ack=%b"},
                                 results_seen, want.scl, want.sda_rel, want.busy, want.done,
                                 want.rd, want.ack, seen.scl, seen.sda_rel, seen.busy,
                                 seen.done, seen.rd, seen.ack);
                end
            end
            results_seen = results_seen + 1;
        end
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("[sccb_bit_level_master_unit] ERROR");
        $finish;
    end

endmodule
